// File: hw/rtl/hps_pkg.sv
// Shared types and constants for the HUB75 panel PWM scanner.
// Used by hps_scan, hps_out and the top module of the block; has no dependencies of its own.

package hps_pkg;

	// Field widths fixed by the pixel and scan formats.
	localparam int COLOR_BITS   = 8;
	localparam int ROW_BITS     = 4;
	localparam int COL_BITS     = 7;
	localparam int WIDTH_BITS   = 7;
	localparam int HEIGHT_BITS  = 6;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 7;

	// Accepted panel geometries.
	localparam logic [WIDTH_BITS-1:0]  WIDTH_NARROW  = 7'd32;
	localparam logic [WIDTH_BITS-1:0]  WIDTH_WIDE    = 7'd64;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_SHORT  = 6'd16;
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_TALL   = 6'd32;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_PANEL_WIDTH   = 2'd0,
		CFG_PANEL_HEIGHT  = 2'd1,
		CFG_MIRROR_SECOND = 2'd2
	} cfg_index_t;

	// Request kinds carried on the input tuser.
	typedef enum logic {
		FUNC_WRITE_PIXEL = 1'b0,
		FUNC_SCAN_TICK   = 1'b1
	} func_t;

	// One stored pixel: red in the top byte, blue in the bottom byte.
	typedef struct packed {
		logic [COLOR_BITS-1:0] red;
		logic [COLOR_BITS-1:0] green;
		logic [COLOR_BITS-1:0] blue;
	} rgb_t;

	localparam int RGB_BITS = $bits(rgb_t);

	// Per-tick control that travels alongside the frame store read.
	typedef struct packed {
		logic [ROW_BITS-1:0]   row_lines;
		logic                  latch;
		logic                  blank;
		logic [COLOR_BITS-1:0] level;
	} scan_info_t;

endpackage

// File: hw/rtl/hps_ram.sv
// Generic simple dual-read RAM: one write port, two registered read ports.
// No dependencies; read data updates only when the read enable is high.

module hps_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read ports, held while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// File: hw/rtl/hps_scan.sv
// Scan sequencer: configuration registers, column/row/PWM counters and the
// frame store addresses of the current chain column. Depends on hps_pkg.

module hps_scan #(
	parameter int MAX_PANEL_WIDTH  = 64,
	parameter int MAX_PANEL_HEIGHT = 32,
	parameter int PWM_STEPS        = 255,
	parameter int AW               = 11
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [hps_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [hps_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
	input  logic                                 tick,
	output logic [hps_pkg::WIDTH_BITS-1:0]       width,
	output logic [hps_pkg::HEIGHT_BITS-1:0]      height,
	output logic [AW-1:0]                        addr_top,
	output logic [AW-1:0]                        addr_bot,
	output hps_pkg::scan_info_t                  info
);

	localparam logic [hps_pkg::WIDTH_BITS-1:0] WIDTH_RESET =
		(MAX_PANEL_WIDTH >= 64) ? hps_pkg::WIDTH_WIDE : hps_pkg::WIDTH_NARROW;
	localparam logic [hps_pkg::HEIGHT_BITS-1:0] HEIGHT_RESET =
		(MAX_PANEL_HEIGHT >= 32) ? hps_pkg::HEIGHT_TALL : hps_pkg::HEIGHT_SHORT;
	localparam logic [8:0] LEVEL_WRAP = 9'(PWM_STEPS);

	logic [hps_pkg::WIDTH_BITS-1:0]  width_q;
	logic [hps_pkg::HEIGHT_BITS-1:0] height_q;
	logic                            mirror_q;
	logic [hps_pkg::COL_BITS-1:0]    col_q;
	logic [hps_pkg::ROW_BITS-1:0]    row_q;
	logic [hps_pkg::COLOR_BITS-1:0]  level_q;

	logic [hps_pkg::HEIGHT_BITS-1:0] cfg_h;
	logic                            width_ok;
	logic                            height_ok;
	logic                            geom_restart;
	logic [7:0]                      two_w;
	logic [7:0]                      last_c;
	logic [7:0]                      mirror_x;
	logic [hps_pkg::COL_BITS-1:0]    src_x;
	logic [4:0]                      half;
	logic [5:0]                      row_plus;
	logic [5:0]                      row_bottom;
	logic                            last_col;
	logic                            last_row;
	logic [8:0]                      level_plus;

	// Configuration decode: only legal geometries are taken.
	assign cfg_h     = cfg_wdata[hps_pkg::HEIGHT_BITS-1:0];
	assign width_ok  = ((cfg_wdata == hps_pkg::WIDTH_NARROW) ||
		(cfg_wdata == hps_pkg::WIDTH_WIDE)) &&
		(32'(cfg_wdata) <= 32'(MAX_PANEL_WIDTH));
	assign height_ok = ((cfg_h == hps_pkg::HEIGHT_SHORT) ||
		(cfg_h == hps_pkg::HEIGHT_TALL)) &&
		(32'(cfg_h) <= 32'(MAX_PANEL_HEIGHT));

	always_comb begin
		geom_restart = 1'b0;
		if (cfg_we) begin
			unique case (hps_pkg::cfg_index_t'(cfg_index))
				hps_pkg::CFG_PANEL_WIDTH:   geom_restart = width_ok;
				hps_pkg::CFG_PANEL_HEIGHT:  geom_restart = height_ok;
				hps_pkg::CFG_MIRROR_SECOND: geom_restart = 1'b0;
				default:                    geom_restart = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			mirror_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (hps_pkg::cfg_index_t'(cfg_index))
				hps_pkg::CFG_PANEL_WIDTH: begin
					if (width_ok) width_q <= cfg_wdata;
				end
				hps_pkg::CFG_PANEL_HEIGHT: begin
					if (height_ok) height_q <= cfg_h;
				end
				hps_pkg::CFG_MIRROR_SECOND: mirror_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Source column of the current chain column: the second panel either
	// repeats the first or reads it right to left.
	assign two_w    = {width_q, 1'b0};
	assign last_c   = two_w - 8'd1;
	assign mirror_x = last_c - {1'b0, col_q};
	always_comb begin
		if (col_q < width_q) begin
			src_x = col_q;
		end else if (mirror_q) begin
			src_x = mirror_x[hps_pkg::COL_BITS-1:0];
		end else begin
			src_x = col_q - width_q;
		end
	end

	assign half       = height_q[hps_pkg::HEIGHT_BITS-1:1];
	assign row_plus   = {2'b00, row_q} + 6'd1;
	assign row_bottom = {2'b00, row_q} + {1'b0, half};
	assign last_col   = ({1'b0, col_q} == last_c);
	assign last_row   = (row_plus >= {1'b0, half});
	assign level_plus = {1'b0, level_q} + 9'd1;

	assign addr_top = AW'(row_q) * AW'(MAX_PANEL_WIDTH) + AW'(src_x);
	assign addr_bot = AW'(row_bottom) * AW'(MAX_PANEL_WIDTH) + AW'(src_x);

	assign info.row_lines = ~row_q;
	assign info.latch     = last_col;
	assign info.blank     = last_col && last_row;
	assign info.level     = level_q;

	assign width  = width_q;
	assign height = height_q;

	// Column, row and PWM level counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			level_q <= '0;
		end else if (geom_restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (tick) begin
			if (!last_col) begin
				col_q <= col_q + 7'd1;
			end else begin
				col_q <= '0;
				if (!last_row) begin
					row_q <= row_plus[hps_pkg::ROW_BITS-1:0];
				end else begin
					row_q <= '0;
					if (level_plus >= LEVEL_WRAP) begin
						level_q <= '0;
					end else begin
						level_q <= level_plus[hps_pkg::COLOR_BITS-1:0];
					end
				end
			end
		end
	end

endmodule

// File: hw/rtl/hps_out.sv
// Output stage: PWM compare of the two frame store reads and the output
// register with its stream handshake. Depends on hps_pkg.

module hps_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick,
	input  hps_pkg::scan_info_t info,
	input  hps_pkg::rgb_t       pix_top,
	input  hps_pkg::rgb_t       pix_bot,
	output logic                ready,
	output logic                valid_s1,
	input  logic                m_tready,
	output logic                m_tvalid,
	output logic [15:0]         m_tdata,
	output logic                m_tlast
);

	hps_pkg::scan_info_t info_s1;
	logic                advance;
	logic                rt;
	logic                gt;
	logic                bt;
	logic                rb;
	logic                gb;
	logic                bb;

	// The read stage may move on whenever the output register is free.
	assign advance = !m_tvalid || m_tready;
	assign ready   = !valid_s1 || advance;

	// Read stage: the control travels while the memory read is in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			info_s1 <= info;
		end
	end

	// A color bit is lit when its component exceeds the PWM level.
	assign rt = pix_top.red   > info_s1.level;
	assign gt = pix_top.green > info_s1.level;
	assign bt = pix_top.blue  > info_s1.level;
	assign rb = pix_bot.red   > info_s1.level;
	assign gb = pix_bot.green > info_s1.level;
	assign bb = pix_bot.blue  > info_s1.level;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			m_tdata <= {5'b00000, info_s1.blank, bb, gb, rb, bt, gt, rt,
				info_s1.row_lines};
			m_tlast <= info_s1.latch;
		end
	end

endmodule

// File: hw/rtl/hub75_panel_pwm_scanner_unit.sv
// HUB75 panel PWM scanner.
// The input stream carries pixel writes and scan ticks, told apart by
// s_tuser. A pixel write stores one RGB pixel of the frame and gives no
// result. A scan tick gives one result: the six color bits of one chain
// column across two chained panels (upper and lower half at once), the
// inverted row address, latch on m_tlast and blank.
// Throughput is one request per cycle of either kind while s_tready is high. A
// scan tick has its frame store read registered in the read stage, then its
// PWM compare registered into the output register, which drives m_tvalid.
// The frame store is a RAM of MAX_PANEL_WIDTH * MAX_PANEL_HEIGHT entries
// (2048 at the defaults) with two read ports for the two halves.
// After reset the store is cleared to black one entry per cycle, and
// s_tready stays low until every entry has been cleared;
// configuration writes are taken at all times.
// When m_tready is low the result waits in the output register, one more
// tick can sit in the read stage, and s_tready drops only after that.
// Configuration writes go through cfg_we/cfg_index/cfg_wdata and take
// effect at once; width and height changes restart the scan.
// Depends on hps_pkg, hps_ram, hps_scan and hps_out.

module hub75_panel_pwm_scanner_unit #(
	parameter int MAX_PANEL_WIDTH  = 64,
	parameter int MAX_PANEL_HEIGHT = 32,
	parameter int PWM_STEPS        = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_wdata,
	// Request stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: pixel_x[5:0], pixel_y[10:6], red_in[18:11], green_in[26:19],
	// blue_in[34:27], zero[39:35].
	input  logic [39:0] s_tdata,
	// s_tuser: func (0 writes a pixel, 1 is a scan tick).
	input  logic        s_tuser,
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: row_lines[3:0], red_top[4], green_top[5], blue_top[6],
	// red_bottom[7], green_bottom[8], blue_bottom[9], blank[10], zero[15:11].
	output logic [15:0] m_tdata,
	// m_tlast: latch_strobe.
	output logic        m_tlast
);

	localparam int DEPTH = MAX_PANEL_WIDTH * MAX_PANEL_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	logic                                 clearing_q;
	logic [AW-1:0]                        clr_addr_q;
	logic                                 out_ready;
	logic                                 valid_s1;
	logic                                 accept;
	logic                                 tick;
	logic                                 pix_we;
	logic [5:0]                           pixel_x;
	logic [4:0]                           pixel_y;
	hps_pkg::rgb_t                        pix_in;
	logic [hps_pkg::WIDTH_BITS-1:0]       width;
	logic [hps_pkg::HEIGHT_BITS-1:0]      height;
	logic [AW-1:0]                        pix_addr;
	logic [AW-1:0]                        addr_top;
	logic [AW-1:0]                        addr_bot;
	hps_pkg::scan_info_t                  info;
	logic                                 ram_we;
	logic [AW-1:0]                        ram_waddr;
	hps_pkg::rgb_t                        ram_wdata;
	hps_pkg::rgb_t                        pix_top;
	hps_pkg::rgb_t                        pix_bot;

	// Request unpacking.
	assign pixel_x      = s_tdata[5:0];
	assign pixel_y      = s_tdata[10:6];
	assign pix_in.red   = s_tdata[18:11];
	assign pix_in.green = s_tdata[26:19];
	assign pix_in.blue  = s_tdata[34:27];

	assign s_tready = out_ready && !clearing_q;
	assign accept   = s_tvalid && s_tready;
	assign tick     = accept && (hps_pkg::func_t'(s_tuser) == hps_pkg::FUNC_SCAN_TICK);

	// Pixel writes outside the configured panel are dropped.
	assign pix_we   = accept && (hps_pkg::func_t'(s_tuser) == hps_pkg::FUNC_WRITE_PIXEL) &&
		({1'b0, pixel_x} < width) && ({1'b0, pixel_y} < height);
	assign pix_addr = AW'(pixel_y) * AW'(MAX_PANEL_WIDTH) + AW'(pixel_x);

	// Clearing pass after reset, one entry per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == LAST_ADDR) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign ram_we    = clearing_q || pix_we;
	assign ram_waddr = clearing_q ? clr_addr_q : pix_addr;
	assign ram_wdata = clearing_q ? '0 : pix_in;

	hps_scan #(
		.MAX_PANEL_WIDTH  (MAX_PANEL_WIDTH),
		.MAX_PANEL_HEIGHT (MAX_PANEL_HEIGHT),
		.PWM_STEPS        (PWM_STEPS),
		.AW               (AW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.tick      (tick),
		.width     (width),
		.height    (height),
		.addr_top  (addr_top),
		.addr_bot  (addr_bot),
		.info      (info)
	);

	hps_ram #(
		.WIDTH (hps_pkg::RGB_BITS),
		.DEPTH (DEPTH)
	) u_frame (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (tick),
		.raddr_a (addr_top),
		.raddr_b (addr_bot),
		.rdata_a (pix_top),
		.rdata_b (pix_bot)
	);

	hps_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick),
		.info     (info),
		.pix_top  (pix_top),
		.pix_bot  (pix_bot),
		.ready    (out_ready),
		.valid_s1 (valid_s1),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// A frame store read never coincides with a write.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && tick))
		else $error("frame store read and write in the same cycle");

	// An accepted scan tick always occupies the read stage next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		tick |=> valid_s1)
		else $error("scan tick lost between accept and read stage");

	// Blank only comes on the last column of a row.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[10] |-> m_tlast)
		else $error("blank without latch");

	// The clearing pass ends only after the last entry has been written.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing_q) |-> ($past(clr_addr_q) == LAST_ADDR))
		else $error("clearing pass ended early");

endmodule

// File: tb/hps_scan_checker.sv
// Scoreboard for the HUB75 panel PWM scanner: tracks configuration writes and
// requests, predicts every scan result and compares it with the result stream.
// Depends on hps_pkg.
`timescale 1ns / 1ps

module hps_scan_checker #(
	parameter int MAX_PANEL_WIDTH  = 64,
	parameter int MAX_PANEL_HEIGHT = 32,
	parameter int PWM_STEPS        = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// s_tdata: pixel_x[5:0], pixel_y[10:6], red_in[18:11], green_in[26:19],
	// blue_in[34:27], zero[39:35].
	input  logic [39:0] s_tdata,
	// s_tuser: func.
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: row_lines[3:0], red_top[4], green_top[5], blue_top[6],
	// red_bottom[7], green_bottom[8], blue_bottom[9], blank[10], zero[15:11].
	input  logic [15:0] m_tdata,
	// m_tlast: latch_strobe.
	input  logic        m_tlast,
	output int          mismatch_count,
	output int          pending_ticks,
	output int          tick_count,
	output int          blank_count
);

	localparam int STORE_DEPTH = MAX_PANEL_WIDTH * MAX_PANEL_HEIGHT;

	// One predicted scan column, as it should leave the block.
	typedef struct packed {
		logic [hps_pkg::ROW_BITS-1:0] row_lines;
		logic                         red_top;
		logic                         green_top;
		logic                         blue_top;
		logic                         red_bottom;
		logic                         green_bottom;
		logic                         blue_bottom;
		logic                         latch;
		logic                         blank;
	} column_bits_t;

	column_bits_t column_bits_q[$];
	column_bits_t want;

	// Shadow of the block's frame, scan position and registers.
	hps_pkg::rgb_t                   frame_mem [0:STORE_DEPTH-1];
	logic [hps_pkg::COLOR_BITS-1:0]  pwm_level;
	logic [hps_pkg::ROW_BITS-1:0]    scan_row;
	logic [hps_pkg::COL_BITS-1:0]    scan_col;
	logic [hps_pkg::WIDTH_BITS-1:0]  width_reg;
	logic [hps_pkg::HEIGHT_BITS-1:0] height_reg;
	logic                            mirror_reg;

	// Register writes; an accepted geometry change restarts the scan.
	function automatic void write_register(logic [1:0] idx, logic [6:0] val);
		logic [hps_pkg::HEIGHT_BITS-1:0] h;
		h = val[hps_pkg::HEIGHT_BITS-1:0];
		case (idx)
			hps_pkg::CFG_PANEL_WIDTH: begin
				if ((val == hps_pkg::WIDTH_NARROW || val == hps_pkg::WIDTH_WIDE) &&
					val <= MAX_PANEL_WIDTH) begin
					width_reg = val;
					scan_row = '0;
					scan_col = '0;
				end
			end
			hps_pkg::CFG_PANEL_HEIGHT: begin
				if ((h == hps_pkg::HEIGHT_SHORT || h == hps_pkg::HEIGHT_TALL) &&
					h <= MAX_PANEL_HEIGHT) begin
					height_reg = h;
					scan_row = '0;
					scan_col = '0;
				end
			end
			hps_pkg::CFG_MIRROR_SECOND: begin
				mirror_reg = val[0];
			end
			default: begin
			end
		endcase
	endfunction

	// Pixels outside the configured panel are dropped.
	function automatic void store_pixel(logic [39:0] data);
		int px;
		int py;
		px = data[5:0];
		py = data[10:6];
		if (px < width_reg && py < height_reg && py * MAX_PANEL_WIDTH + px < STORE_DEPTH) begin
			frame_mem[py * MAX_PANEL_WIDTH + px] = {data[18:11], data[26:19], data[34:27]};
		end
	endfunction

	// Works out the column that one scan tick shifts out, then advances
	// column, row and PWM level the way the panel sequencing does.
	function automatic column_bits_t next_scan_column();
		int w;
		int half;
		int c;
		int x;
		int top_addr;
		int bot_addr;
		hps_pkg::rgb_t top_px;
		hps_pkg::rgb_t bot_px;
		logic last_col;
		logic last_row;
		column_bits_t r;
		w = width_reg;
		half = height_reg / 2;
		c = scan_col;
		if (c >= 2 * w)
			c = 2 * w - 1;
		if (c < w)
			x = c;
		else if (mirror_reg)
			x = 2 * w - 1 - c;
		else
			x = c - w;
		top_addr = int'(scan_row) * MAX_PANEL_WIDTH + x;
		bot_addr = (int'(scan_row) + half) * MAX_PANEL_WIDTH + x;
		top_px = (top_addr < STORE_DEPTH) ? frame_mem[top_addr] : '0;
		bot_px = (bot_addr < STORE_DEPTH) ? frame_mem[bot_addr] : '0;
		last_col = (c == 2 * w - 1);
		last_row = (int'(scan_row) + 1 >= half);

		r.row_lines    = ~scan_row;
		r.red_top      = top_px.red > pwm_level;
		r.green_top    = top_px.green > pwm_level;
		r.blue_top     = top_px.blue > pwm_level;
		r.red_bottom   = bot_px.red > pwm_level;
		r.green_bottom = bot_px.green > pwm_level;
		r.blue_bottom  = bot_px.blue > pwm_level;
		r.latch        = last_col;
		r.blank        = last_col && last_row;

		if (!last_col) begin
			scan_col = hps_pkg::COL_BITS'(c + 1);
		end else begin
			scan_col = '0;
			if (!last_row) begin
				scan_row = scan_row + 1'b1;
			end else begin
				scan_row = '0;
				if (int'(pwm_level) + 1 >= PWM_STEPS)
					pwm_level = '0;
				else
					pwm_level = pwm_level + 1'b1;
			end
		end
		return r;
	endfunction

	task automatic check_field(string name, int expected_val, int actual_val);
		if (expected_val != actual_val) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, expected_val, actual_val);
			mismatch_count++;
		end
	endtask

	// Watch configuration, requests and results on every edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++)
				frame_mem[i] = '0;
			pwm_level  = '0;
			scan_row   = '0;
			scan_col   = '0;
			width_reg  = (MAX_PANEL_WIDTH >= 64) ? hps_pkg::WIDTH_WIDE : hps_pkg::WIDTH_NARROW;
			height_reg = (MAX_PANEL_HEIGHT >= 32) ? hps_pkg::HEIGHT_TALL : hps_pkg::HEIGHT_SHORT;
			mirror_reg = 1'b0;
			column_bits_q.delete();
			pending_ticks <= 0;
		end else begin
			if (cfg_we)
				write_register(cfg_index, cfg_wdata);

			if (s_tvalid && s_tready) begin
				if (s_tuser == hps_pkg::FUNC_SCAN_TICK)
					column_bits_q.push_back(next_scan_column());
				else
					store_pixel(s_tdata);
			end

			if (m_tvalid && m_tready) begin
				if (column_bits_q.size() == 0) begin
					$display("%0t: result with nothing expected, got data %h last %b",
						$time, m_tdata, m_tlast);
					mismatch_count++;
				end else begin
					want = column_bits_q.pop_front();
					check_field("row_lines", want.row_lines, m_tdata[3:0]);
					check_field("red_top", want.red_top, m_tdata[4]);
					check_field("green_top", want.green_top, m_tdata[5]);
					check_field("blue_top", want.blue_top, m_tdata[6]);
					check_field("red_bottom", want.red_bottom, m_tdata[7]);
					check_field("green_bottom", want.green_bottom, m_tdata[8]);
					check_field("blue_bottom", want.blue_bottom, m_tdata[9]);
					check_field("blank", want.blank, m_tdata[10]);
					check_field("padding", 0, m_tdata[15:11]);
					check_field("latch_strobe", want.latch, m_tlast);
					tick_count++;
					if (want.blank)
						blank_count++;
				end
			end

			pending_ticks <= column_bits_q.size();
		end
	end

endmodule

// File: tb/tb.sv
// Top of the HUB75 panel PWM scanner testbench: clock, reset, requests,
// configuration and result back-pressure; the verdict comes from hps_scan_checker.
// Depends on hps_pkg, hps_scan_checker and the scanner RTL.
`timescale 1ns / 1ps

module tb;

	localparam int MAX_PANEL_WIDTH  = 64;
	localparam int MAX_PANEL_HEIGHT = 32;
	localparam int PWM_STEPS        = 255;
	localparam int HALF_PERIOD      = 6;
	localparam int RESET_CYCLES     = 10;
	localparam int SETTLE_CYCLES    = 8;
	localparam int RX_HOLD_CYCLES   = 300;
	localparam int TIMEOUT_NS       = 3_000_000;
	// Index with no register behind it.
	localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [6:0]  cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;

	int mismatch_count;
	int pending_ticks;
	int tick_count;
	int blank_count;
	int n_writes;
	int n_ticks;
	bit quiet;
	bit hold_request;

	always #(HALF_PERIOD) clk = ~clk;

	hub75_panel_pwm_scanner_unit #(
		.MAX_PANEL_WIDTH (MAX_PANEL_WIDTH),
		.MAX_PANEL_HEIGHT(MAX_PANEL_HEIGHT),
		.PWM_STEPS       (PWM_STEPS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	hps_scan_checker #(
		.MAX_PANEL_WIDTH (MAX_PANEL_WIDTH),
		.MAX_PANEL_HEIGHT(MAX_PANEL_HEIGHT),
		.PWM_STEPS       (PWM_STEPS)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.mismatch_count(mismatch_count),
		.pending_ticks (pending_ticks),
		.tick_count    (tick_count),
		.blank_count   (blank_count)
	);

	// Result side: random stalls per result, or one long hold when asked.
	initial begin : result_sink
		int stall;
		forever begin
			if (hold_request) begin
				stall = RX_HOLD_CYCLES;
				hold_request = 1'b0;
			end else begin
				stall = quiet ? 0 : $urandom_range(0, 7);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Offers one request after a random gap and waits until it is taken.
	task automatic send_request(input hps_pkg::func_t func, input logic [5:0] x,
		input logic [4:0] y, input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {5'b0, b, g, r, y, x};
		do @(posedge clk); while (!s_tready);
		if (func == hps_pkg::FUNC_SCAN_TICK)
			n_ticks++;
		else
			n_writes++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Drain every expected column, then give a trailing pixel write time to land.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_ticks != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Low values are favored so that the compare against small PWM levels
	// sees both outcomes.
	function automatic logic [7:0] pick_color();
		return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
	endfunction

	// Mostly in-panel writes and scan ticks; some writes land anywhere.
	task automatic run_phase(input int n_items, input int tick_pct, input int w, input int h,
		input int hold_at);
		logic [5:0] x;
		logic [4:0] y;
		for (int i = 0; i < n_items; i++) begin
			if (i == hold_at) begin
				quiet = 1'b1;
				hold_request = 1'b1;
			end else if (i % 50 == 0) begin
				quiet = ($urandom_range(0, 3) == 0);
			end
			if ($urandom_range(0, 99) < 15) begin
				x = 6'($urandom_range(0, 63));
				y = 5'($urandom_range(0, 31));
			end else begin
				x = 6'($urandom_range(0, w - 1));
				y = 5'($urandom_range(0, h - 1));
			end
			if ($urandom_range(0, 99) < tick_pct)
				send_request(hps_pkg::FUNC_SCAN_TICK, x, y, pick_color(), pick_color(),
					pick_color());
			else
				send_request(hps_pkg::FUNC_WRITE_PIXEL, x, y, pick_color(), pick_color(),
					pick_color());
		end
	endtask

	initial begin : stimulus
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Reset geometry: corner pixels, both halves, color extremes.
		send_request(hps_pkg::FUNC_WRITE_PIXEL, 6'd0, 5'd0, 8'd255, 8'd1, 8'd0);
		send_request(hps_pkg::FUNC_WRITE_PIXEL, 6'd0, 5'd16, 8'd0, 8'd255, 8'd128);
		send_request(hps_pkg::FUNC_WRITE_PIXEL, 6'd63, 5'd31, 8'd1, 8'd0, 8'd255);
		send_request(hps_pkg::FUNC_WRITE_PIXEL, 6'd63, 5'd15, 8'd128, 8'd127, 8'd2);
		send_request(hps_pkg::FUNC_WRITE_PIXEL, 6'd1, 5'd0, 8'd0, 8'd0, 8'd0);
		send_request(hps_pkg::FUNC_SCAN_TICK, 6'h3f, 5'h1f, 8'hff, 8'hff, 8'hff);
		send_request(hps_pkg::FUNC_SCAN_TICK, 6'h00, 5'h00, 8'h00, 8'h00, 8'h00);
		send_request(hps_pkg::FUNC_SCAN_TICK, 6'h2a, 5'h15, 8'h55, 8'haa, 8'h0f);
		wait_idle();

		// Rejected geometry values and the unused index leave everything alone.
		write_reg(hps_pkg::CFG_PANEL_WIDTH, 7'd48);
		write_reg(hps_pkg::CFG_PANEL_WIDTH, 7'd127);
		write_reg(hps_pkg::CFG_PANEL_WIDTH, 7'd0);
		write_reg(hps_pkg::CFG_PANEL_HEIGHT, 7'd24);
		write_reg(hps_pkg::CFG_PANEL_HEIGHT, 7'd63);
		write_reg(hps_pkg::CFG_PANEL_HEIGHT, 7'd0);
		write_reg(CFG_SPARE_INDEX, 7'd127);
		send_request(hps_pkg::FUNC_SCAN_TICK, 6'd0, 5'd0, 8'd0, 8'd0, 8'd0);
		wait_idle();

		// Smallest geometry, mirrored second panel.
		write_reg(hps_pkg::CFG_PANEL_WIDTH, 7'd32);
		write_reg(hps_pkg::CFG_PANEL_HEIGHT, 7'd16);
		write_reg(hps_pkg::CFG_MIRROR_SECOND, 7'd1);
		send_request(hps_pkg::FUNC_WRITE_PIXEL, 6'd40, 5'd3, 8'd255, 8'd255, 8'd255);
		send_request(hps_pkg::FUNC_WRITE_PIXEL, 6'd3, 5'd20, 8'd255, 8'd255, 8'd255);
		send_request(hps_pkg::FUNC_WRITE_PIXEL, 6'd31, 5'd0, 8'd2, 8'd0, 8'd1);
		send_request(hps_pkg::FUNC_WRITE_PIXEL, 6'd0, 5'd8, 8'd0, 8'd1, 8'd0);
		send_request(hps_pkg::FUNC_SCAN_TICK, 6'd0, 5'd0, 8'd0, 8'd0, 8'd0);
		send_request(hps_pkg::FUNC_SCAN_TICK, 6'd0, 5'd0, 8'd0, 8'd0, 8'd0);

		// Long scan run: rows latch, the subframe blanks and the level steps.
		run_phase(600, 93, 32, 16, 100);
		wait_idle();

		// Height value with the high bit set still selects sixteen rows.
		write_reg(hps_pkg::CFG_PANEL_HEIGHT, 7'd80);
		write_reg(hps_pkg::CFG_PANEL_WIDTH, 7'd64);
		write_reg(hps_pkg::CFG_MIRROR_SECOND, 7'd1);
		run_phase(30, 60, 64, 16, -1);
		wait_idle();

		write_reg(hps_pkg::CFG_PANEL_WIDTH, 7'd32);
		write_reg(hps_pkg::CFG_PANEL_HEIGHT, 7'd32);
		write_reg(hps_pkg::CFG_MIRROR_SECOND, 7'd0);
		run_phase(30, 60, 32, 32, -1);
		wait_idle();

		write_reg(hps_pkg::CFG_PANEL_WIDTH, 7'd64);
		write_reg(hps_pkg::CFG_PANEL_HEIGHT, 7'd32);
		write_reg(hps_pkg::CFG_MIRROR_SECOND, 7'd1);
		run_phase(40, 60, 64, 32, -1);
		wait_idle();

		$display("Sent %0d pixel writes and %0d scan ticks across five panel settings.",
			n_writes, n_ticks);
		$display("Checked %0d scan columns, %0d of them ending a subframe.",
			tick_count, blank_count);
		if (mismatch_count == 0 && pending_ticks == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("simulation failed");
		$finish;
	end

endmodule
